>>> rtl/plee_pkg.sv
// package for the patch list escape encoder: constants, types and helpers
package plee_pkg;

  localparam int MAX_SECTION_LEN = 512;
  localparam int PASS_COUNT      = 2;
  localparam int POS_W           = $clog2(MAX_SECTION_LEN + 1);
  localparam int PASS_W          = $clog2(PASS_COUNT + 1);
  localparam int PADDR_W         = 3;
  localparam int NSLOT           = 4;

  localparam logic [7:0] SCAN_BASE  = 8'h13;
  localparam logic [7:0] LIST_START = 8'd7;
  localparam logic [7:0] PASS_LEN   = 8'hFC;
  localparam logic [7:0] RESERVED   = 8'hFE;
  localparam logic [7:0] MARK       = 8'hFF;
  localparam logic [7:0] LEN_RESET  = 8'd200;

  // register index, taken from paddr[2]
  localparam logic REG_PATCH_LIST_LEN = 1'b0;

  typedef logic [1:0] slot_t;
  localparam slot_t SLOT_BYTE  = 2'd0;
  localparam slot_t SLOT_POS   = 2'd1;
  localparam slot_t SLOT_PASS  = 2'd2;
  localparam slot_t SLOT_FINAL = 2'd3;

  // all results of one item, in emission order
  typedef struct packed {
    logic [NSLOT-1:0]      vld;
    logic [NSLOT-1:0][7:0] value;
    logic [NSLOT-1:0][7:0] index;
  } bundle_t;

  function automatic logic has_room(input logic [7:0] wi, input logic [7:0] len);
    logic [8:0] pos;
    pos = {1'b0, LIST_START} + {1'b0, wi};
    return pos < {1'b0, len};
  endfunction

endpackage

>>> rtl/plee_if.sv
// item channels for input bytes and results
interface plee_in_if;
  import plee_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface plee_out_if;
  import plee_pkg::*;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] value;
  logic [7:0] list_index;
  logic       run_end;

  modport source (output valid, output kind, output value, output list_index,
                  output run_end, input ready);
  modport sink (input valid, input kind, input value, input list_index,
                input run_end, output ready);
endinterface

>>> rtl/patch_list_escape_encoder_top.sv
// Top level of the patch list escape encoder.
// Latency: the first result of an item (the section byte) is valid in the cycle after accept.
// Throughput: one item per cycle while each item yields a single result and the receiver is
// ready; an item with n results (1 to 4) holds the one-deep result register until all are taken.
// Reset (rst, synchronous): scan state returns to section start, patch_list_len to 200,
// the result register empties.
module patch_list_escape_encoder_top
  import plee_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  plee_in_if.sink            in_ch,
  plee_out_if.source         out_ch
);

  logic       [7:0] list_len;
  logic             can_load;
  logic             take;
  bundle_t          bundle;

  assign in_ch.ready = can_load;
  assign take        = in_ch.valid && can_load;

  plee_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .list_len (list_len)
  );

  plee_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (in_ch.data_byte),
    .last      (in_ch.last),
    .list_len  (list_len),
    .bundle    (bundle)
  );

  plee_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (take),
    .bundle     (bundle),
    .can_load   (can_load),
    .valid      (out_ch.valid),
    .ready      (out_ch.ready),
    .kind       (out_ch.kind),
    .value      (out_ch.value),
    .list_index (out_ch.list_index),
    .run_end    (out_ch.run_end)
  );

  // finishing the last result of an item frees the result register
  a_free_on_end: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && out_ch.run_end |-> in_ch.ready)
    else $error("result register not freed after last result");

  // every item starts with its section byte
  a_byte_first: assert property (@(posedge clk) disable iff (rst)
    take |=> out_ch.valid && !out_ch.kind)
    else $error("item did not start with its section byte");

  // list entries never land below the list start
  a_entry_index: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.kind |-> out_ch.list_index >= LIST_START)
    else $error("patch entry below list start");

  // section bytes carry list index zero
  a_byte_index: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.kind |-> out_ch.list_index == 8'd0)
    else $error("section byte with nonzero list index");

endmodule

>>> rtl/plee_cfg.sv
// apb register block holding the patch list length
module plee_cfg
  import plee_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [7:0]         list_len
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      list_len <= LEN_RESET;
    end else if (wr && paddr[2] == REG_PATCH_LIST_LEN) begin
      list_len <= pwdata[7:0];
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PATCH_LIST_LEN: prdata = {24'd0, list_len};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/plee_scan.sv
// scan state and per-item result computation
module plee_scan
  import plee_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       last,
  input  logic [7:0] list_len,
  output bundle_t    bundle
);

  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [7:0]        pass_offset, pass_offset_next;
  logic [7:0]        write_index, write_index_next;
  logic [PASS_W-1:0] passes_left, passes_left_next;
  logic              scan_done, scan_done_next;

  logic       in_region, scan, stop, hit;
  logic [7:0] po_inc;

  always_comb begin
    in_region          = !scan_done && (byte_position >= POS_W'(SCAN_BASE));
    scan               = in_region && (passes_left != '0) && has_room(write_index, list_len);
    stop               = in_region && !scan;
    hit                = scan && (data_byte == RESERVED);
    po_inc             = pass_offset + 8'd1;
    write_index_next   = write_index;
    pass_offset_next   = pass_offset;
    passes_left_next   = passes_left;
    scan_done_next     = scan_done;
    byte_position_next = byte_position;

    bundle                  = '0;
    bundle.vld[SLOT_BYTE]   = 1'b1;
    bundle.value[SLOT_BYTE] = hit ? MARK : data_byte;

    if (scan) begin
      if (hit) begin
        bundle.vld[SLOT_POS]   = 1'b1;
        bundle.value[SLOT_POS] = po_inc;
        bundle.index[SLOT_POS] = LIST_START + write_index_next;
        write_index_next       = write_index_next + 8'd1;
      end
      if (po_inc >= PASS_LEN) begin
        pass_offset_next = '0;
        if (has_room(write_index_next, list_len)) begin
          bundle.vld[SLOT_PASS]   = 1'b1;
          bundle.value[SLOT_PASS] = MARK;
          bundle.index[SLOT_PASS] = LIST_START + write_index_next;
          write_index_next        = write_index_next + 8'd1;
        end
        passes_left_next = passes_left - PASS_W'(1);
      end else begin
        pass_offset_next = po_inc;
      end
      if (passes_left_next == '0 || !has_room(write_index_next, list_len)) begin
        stop = 1'b1;
      end
    end

    if (!scan_done && last) begin
      stop = 1'b1;
    end

    // closing sentinel, at most once per section
    if (stop && !scan_done) begin
      if (has_room(write_index_next, list_len)) begin
        bundle.vld[SLOT_FINAL]   = 1'b1;
        bundle.value[SLOT_FINAL] = MARK;
        bundle.index[SLOT_FINAL] = LIST_START + write_index_next;
      end
      scan_done_next = 1'b1;
    end

    if (last) begin
      byte_position_next = '0;
      pass_offset_next   = '0;
      write_index_next   = '0;
      passes_left_next   = PASS_W'(PASS_COUNT);
      scan_done_next     = 1'b0;
    end else if (byte_position < POS_W'(MAX_SECTION_LEN)) begin
      byte_position_next = byte_position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      pass_offset   <= '0;
      write_index   <= '0;
      passes_left   <= PASS_W'(PASS_COUNT);
      scan_done     <= 1'b0;
    end else if (take) begin
      byte_position <= byte_position_next;
      pass_offset   <= pass_offset_next;
      write_index   <= write_index_next;
      passes_left   <= passes_left_next;
      scan_done     <= scan_done_next;
    end
  end

endmodule

>>> rtl/plee_out.sv
// result register that hands out the results of one item, one per cycle while the receiver is ready
module plee_out
  import plee_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  bundle_t    bundle,
  output logic       can_load,
  output logic       valid,
  input  logic       ready,
  output logic       kind,
  output logic [7:0] value,
  output logic [7:0] list_index,
  output logic       run_end
);

  logic [NSLOT-1:0]      vld;
  logic [NSLOT-1:0][7:0] val_q;
  logic [NSLOT-1:0][7:0] idx_q;
  slot_t                 sel;
  logic [NSLOT-1:0]      sel_mask;
  logic                  pop;

  // lowest pending slot goes first
  always_comb begin
    sel = SLOT_BYTE;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (vld[i]) begin
        sel = slot_t'(i);
      end
    end
    sel_mask = NSLOT'(1) << sel;
  end

  assign valid      = vld != '0;
  assign kind       = sel != SLOT_BYTE;
  assign value      = val_q[sel];
  assign list_index = idx_q[sel];
  assign run_end    = (vld & ~sel_mask) == '0;
  assign pop        = valid && ready;
  assign can_load   = !valid || (pop && run_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (load) begin
      vld <= bundle.vld;
    end else if (pop) begin
      vld <= vld & ~sel_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      val_q <= bundle.value;
      idx_q <= bundle.index;
    end
  end

endmodule

>>> tb/plee_result_monitor.sv
// result monitor: predicts the escaped stream and patch list entries, compares accepted results
`timescale 1ns / 1ps
module plee_result_monitor
  import plee_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  plee_in_if                 in_ch,
  plee_out_if                out_ch,
  output int                 bad_results,
  output int                 open_count
);

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic [7:0] list_index;
    logic       run_end;
  } enc_result_t;

  enc_result_t pending_results[$];
  enc_result_t want;

  // section state, mirrored from the block
  logic [POS_W-1:0]  sec_pos;
  logic [7:0]        pass_ofs;
  logic [7:0]        wr_idx;
  logic [PASS_W-1:0] passes_rem;
  logic              scan_stopped;
  logic [7:0]        list_len;

  function automatic logic has_space(input logic [7:0] wi);
    return int'(LIST_START) + int'(wi) < int'(list_len);
  endfunction

  task automatic clear_section();
    sec_pos      = '0;
    pass_ofs     = '0;
    wr_idx       = '0;
    passes_rem   = PASS_W'(PASS_COUNT);
    scan_stopped = 1'b0;
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic lst);
    logic        in_region;
    logic        scan;
    logic        stop;
    logic        hit;
    enc_result_t r;
    in_region = !scan_stopped && sec_pos >= SCAN_BASE;
    scan      = in_region && passes_rem != 0 && has_space(wr_idx);
    stop      = in_region && !scan;
    hit       = scan && b == RESERVED;
    pending_results.push_back('{1'b0, (hit ? MARK : b), 8'd0, 1'b0});
    if (scan) begin
      if (hit) begin
        pending_results.push_back('{1'b1, pass_ofs + 8'd1, LIST_START + wr_idx, 1'b0});
        wr_idx = wr_idx + 8'd1;
      end
      pass_ofs = pass_ofs + 8'd1;
      if (pass_ofs >= PASS_LEN) begin
        pass_ofs = '0;
        if (has_space(wr_idx)) begin
          pending_results.push_back('{1'b1, MARK, LIST_START + wr_idx, 1'b0});
          wr_idx = wr_idx + 8'd1;
        end
        passes_rem = passes_rem - 1'b1;
      end
      if (passes_rem == 0 || !has_space(wr_idx)) stop = 1'b1;
    end
    if (!scan_stopped && lst) stop = 1'b1;
    if (stop && !scan_stopped) begin
      if (has_space(wr_idx)) pending_results.push_back('{1'b1, MARK, LIST_START + wr_idx, 1'b0});
      scan_stopped = 1'b1;
    end
    if (lst) begin
      clear_section();
    end else if (sec_pos < MAX_SECTION_LEN) begin
      sec_pos = sec_pos + 1'b1;
    end
    // flag the last result of this item
    r = pending_results.pop_back();
    r.run_end = 1'b1;
    pending_results.push_back(r);
  endtask

  initial bad_results = 0;

  always @(posedge clk) begin
    if (rst) begin
      clear_section();
      list_len = LEN_RESET;
      pending_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_PATCH_LIST_LEN) begin
        list_len = pwdata[7:0];
      end
      if (in_ch.valid && in_ch.ready) encode_byte(in_ch.data_byte, in_ch.last);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%0t: unexpected result kind=%0b value=%02h index=%0d end=%0b", $realtime,
                     out_ch.kind, out_ch.value, out_ch.list_index, out_ch.run_end);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.kind !== want.kind || out_ch.value !== want.value ||
              out_ch.list_index !== want.list_index || out_ch.run_end !== want.run_end) begin
            bad_results++;
            if (bad_results <= 10)
              $display("%0t: mismatch exp kind=%0b value=%02h index=%0d end=%0b, got kind=%0b value=%02h index=%0d end=%0b",
                       $realtime, want.kind, want.value, want.list_index, want.run_end,
                       out_ch.kind, out_ch.value, out_ch.list_index, out_ch.run_end);
          end
        end
      end
    end
    open_count <= pending_results.size();
  end

endmodule

>>> tb/patch_list_escape_encoder_top_tb.sv
// testbench top: reset, register writes, section stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module patch_list_escape_encoder_top_tb;
  import plee_pkg::*;

  localparam logic [PADDR_W-1:0] ADDR_LIST_LEN = {REG_PATCH_LIST_LEN, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_SPARE    = {~REG_PATCH_LIST_LEN, 2'b00};
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 30;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int   bad_results;
  int   open_count;
  int   burst_left = 0;
  int   sent_count = 0;
  logic hold_req   = 1'b0;

  plee_in_if  in_ch ();
  plee_out_if out_ch ();

  patch_list_escape_encoder_top dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  plee_result_monitor result_monitor (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .bad_results (bad_results),
    .open_count  (open_count)
  );

  always #10 clk = ~clk;

  initial begin
    #4ms;
    $display("patch_list_escape_encoder_top_tb: FAIL");
    $finish;
  end

  // receiver: changing stall styles, plus one long hold on request
  initial begin : receiver
    int run_left;
    int style;
    logic [7:0] pat;
    logic [2:0] tick;
    run_left = 0;
    style = 0;
    pat = '1;
    tick = '0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (run_left == 0) begin
          style = $urandom_range(0, 3);
          run_left = $urandom_range(10, 80);
          pat = 8'($urandom_range(1, 255));
        end
        run_left--;
        tick++;
        case (style)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= pat[tick];
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last      <= lst;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    sent_count++;
  endtask

  function automatic logic [7:0] pick_byte(input int fe_pct);
    return ($urandom_range(0, 99) < fe_pct) ? RESERVED : 8'($urandom_range(0, 255));
  endfunction

  // the byte that closes a full pass is made reserved, to get the most results per item
  task automatic send_section(input int len, input int fe_pct, input logic closed);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = pick_byte(fe_pct);
      if (i >= SCAN_BASE && (i - SCAN_BASE) % PASS_LEN == PASS_LEN - 1) b = RESERVED;
      send_byte(b, closed && i == len - 1);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [7:0] val);
    logic [31:0] word;
    word = $urandom();
    word[7:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    int base;
    int nsec;
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last      <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one-byte section ending before the scan region
    reg_write(ADDR_LIST_LEN, LEN_RESET);
    send_byte(RESERVED, 1'b1);

    // one full pass with a long receiver hold while items keep coming;
    // the last byte closes the pass and the section at once
    wait_idle();
    hold_req = 1'b1;
    send_section(SCAN_BASE + PASS_LEN, 8, 1'b1);

    // list shrunk in the middle of a scan
    wait_idle();
    reg_write(ADDR_LIST_LEN, 8'd255);
    send_section(26, 60, 1'b0);
    wait_idle();
    reg_write(ADDR_LIST_LEN, 8'd9);
    send_section(4, 30, 1'b1);

    // random phases with changing list lengths
    base = sent_count;
    while (sent_count - base < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 7))
        0: reg_write(ADDR_LIST_LEN, 8'd8);
        1: reg_write(ADDR_LIST_LEN, 8'd255);
        2: reg_write(ADDR_LIST_LEN, 8'($urandom_range(0, 7)));
        3: reg_write(ADDR_SPARE, 8'($urandom_range(0, 255)));
        default: reg_write(ADDR_LIST_LEN, 8'($urandom_range(8, 40)));
      endcase
      nsec = $urandom_range(1, 2);
      repeat (nsec) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 12))
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end else begin
          send_section($urandom_range(1, 32), $urandom_range(0, 50), $urandom_range(0, 7) != 0);
        end
      end
    end

    wait_idle();
    if (bad_results == 0 && open_count == 0) begin
      $display("patch_list_escape_encoder_top_tb: PASS");
    end else begin
      $display("patch_list_escape_encoder_top_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/plee_pkg.sv
rtl/plee_if.sv
rtl/plee_cfg.sv
rtl/plee_scan.sv
rtl/plee_out.sv
rtl/patch_list_escape_encoder_top.sv
tb/plee_result_monitor.sv
tb/patch_list_escape_encoder_top_tb.sv
